// ===== src/path_hash_handle_table_top_assert.svh =====
// assertion macros for the handle table top level
// depends on nothing; included by path_hash_handle_table_top
`ifndef PATH_HASH_HANDLE_TABLE_TOP_ASSERT_SVH
`define PATH_HASH_HANDLE_TABLE_TOP_ASSERT_SVH
// implication checked on every clock, off during reset
`define PHT_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("pht check failed");
// next-cycle implication, off during reset
`define PHT_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("pht check failed");
`endif

// ===== src/pht_pkg.sv =====
// package for the handle table: sizes, fnv constants, status and state codes
// depends on nothing
package pht_pkg;
	localparam int POOL_ENTRIES = 128;
	localparam int NAME_BYTES = 64;
	localparam int IDX_W = $clog2(POOL_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int LEN_W = 7;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [7:0] SLASH_BYTE = 8'd47;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_NEW = 3'd0,
		ST_OK = 3'd1,
		ST_FULL = 3'd2,
		ST_BADLEN = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEED,
		S_PAR,
		S_HASH,
		S_SCAN,
		S_DONE,
		S_OUT
	} state_t;

	// low 32 bits of the product only
	function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
		return (h ^ v) * FNV_PRIME;
	endfunction
endpackage

// ===== src/path_hash_handle_table_top.sv =====
// handle table top level: fnv-1a path hash, slot memories, scan sequencer
// depends on pht_pkg and path_hash_handle_table_top_assert.svh
//
// channel  dir  handshake      fields
// in       in   valid / stall  mode .. target_handle
// out      out  valid / stall  status .. live_count
//
// a non-final path byte runs S_HASH, after S_SEED and S_PAR if it starts a path
// a free or lookup runs a handle scan of all POOL_ENTRIES slots through the
// registered memory read, then S_DONE (write-back for a free), S_OUT and idle
// a final byte runs S_HASH, then those steps; S_SEED, S_PAR first on a new path
// the handle memory is cleared slot by slot after reset, with no item taken
// a stalled result waits in the output register; a second one holds the input
`include "path_hash_handle_table_top_assert.svh"
module path_hash_handle_table_top import pht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  path_byte,
	input  logic        last_byte,
	input  logic [31:0] store_id,
	input  logic [31:0] parent_obj,
	input  logic [15:0] object_format,
	input  logic [31:0] object_size,
	input  logic        is_directory,
	input  logic [31:0] target_handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] result_handle,
	output logic [31:0] found_storage,
	output logic [31:0] found_parent,
	output logic [15:0] found_format,
	output logic [31:0] found_size,
	output logic        found_is_dir,
	output logic [7:0]  live_count
);
	logic [31:0] mem_handle [POOL_ENTRIES];
	logic [31:0] mem_storage [POOL_ENTRIES];
	logic [31:0] mem_parent [POOL_ENTRIES];
	logic [15:0] mem_format [POOL_ENTRIES];
	logic [31:0] mem_size [POOL_ENTRIES];
	logic        mem_dir [POOL_ENTRIES];

	state_t state_q, state_d;
	logic        clr_q;
	logic [CNT_W-1:0] clr_idx_q;
	logic [1:0]  op_mode_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [15:0] fmt_q;
	logic [31:0] size_q;
	logic        dir_q;
	logic [31:0] key_q;
	logic [31:0] hash_q;
	logic        first_q;
	logic [31:0] held_storage_q, held_parent_q;
	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] live_q;
	logic [CNT_W-1:0] scan_q;
	logic        rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [31:0] rd_handle_s1;
	logic        hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [31:0] rd_storage_q, rd_parent_q, rd_size_q;
	logic [15:0] rd_format_q;
	logic        rd_dir_q;
	logic        acc, step_last, scan_end;
	logic [31:0] handle_c, hash_c;
	logic        out_load;
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_handle_q, out_storage_q, out_parent_q, out_size_q;
	logic [15:0] out_format_q;
	logic        out_dir_q;
	logic [7:0]  out_count_q;
	logic [2:0]  status_c;
	logic [31:0] result_c;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || clr_q;
	assign scan_end = !rd_vld_s1 && (scan_q == CNT_W'(POOL_ENTRIES));
	assign hash_c = fnv_mix(hash_q, {24'd0, byte_q});
	assign handle_c = ((hash_q & 32'hFFFFFFFE) == 32'd0) ? 32'd1 : (hash_q & 32'hFFFFFFFE);
	assign step_last = last_q;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (mode_t'(mode))
						MODE_ALLOC: state_d = first_q ? S_SEED : S_HASH;
						MODE_FREE, MODE_LOOKUP: state_d = S_SCAN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SEED: state_d = S_PAR;
			S_PAR: state_d = S_HASH;
			S_HASH: state_d = step_last ? S_SCAN : S_IDLE;
			S_SCAN: if (scan_end) state_d = S_DONE;
			S_DONE: state_d = S_OUT;
			S_OUT: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			first_q <= 1'b1;
			hash_q <= '0;
			len_q <= '0;
			live_q <= '0;
			held_storage_q <= '0;
			held_parent_q <= '0;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == CNT_W'(POOL_ENTRIES - 1)) clr_q <= 1'b0;
			end
			if (acc && mode_t'(mode) == MODE_ALLOC && first_q) begin
				held_storage_q <= store_id;
				held_parent_q <= parent_obj;
			end
			if (state_q == S_SEED) begin
				hash_q <= fnv_mix(FNV_BASIS, {held_storage_q[23:0], held_storage_q[31:24]});
			end
			if (state_q == S_PAR) begin
				hash_q <= fnv_mix(hash_q, held_parent_q);
			end
			if (state_q == S_HASH) begin
				hash_q <= hash_c;
				first_q <= 1'b0;
				if (first_q) begin
					len_q <= (byte_q == SLASH_BYTE) ? '0 : LEN_W'(1);
				end else if (byte_q == SLASH_BYTE) begin
					len_q <= '0;
				end else if (len_q < LEN_W'(NAME_BYTES)) begin
					len_q <= len_q + 1'b1;
				end
			end
			if (state_q == S_HASH || (acc && mode_t'(mode) != MODE_ALLOC)) begin
				scan_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				rd_vld_s1 <= 1'b0;
			end else if (state_q == S_SCAN) begin
				rd_vld_s1 <= scan_q < CNT_W'(POOL_ENTRIES);
				rd_idx_s1 <= scan_q[IDX_W-1:0];
				if (scan_q < CNT_W'(POOL_ENTRIES)) scan_q <= scan_q + 1'b1;
				if (rd_vld_s1) begin
					if (!hit_q && key_q != '0 && rd_handle_s1 == key_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= rd_idx_s1;
					end
					if (!free_q && rd_handle_s1 == '0) begin
						free_q <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
				end
			end
			if (state_q == S_DONE) begin
				unique case (mode_t'(op_mode_q))
					MODE_ALLOC: begin
						first_q <= 1'b1;
						if (!hit_q && free_q && len_q != '0 && len_q < LEN_W'(NAME_BYTES))
							live_q <= live_q + 1'b1;
					end
					MODE_FREE: if (hit_q && live_q != '0) live_q <= live_q - 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_mode_q <= mode;
			byte_q <= path_byte;
			last_q <= last_byte;
			fmt_q <= object_format;
			size_q <= object_size;
			dir_q <= is_directory;
			if (mode_t'(mode) != MODE_ALLOC) key_q <= target_handle;
		end else if (state_q == S_SCAN && scan_q == '0 && !rd_vld_s1
				&& op_mode_q == MODE_ALLOC) begin
			key_q <= handle_c;
		end
	end

	// handle memory: scan read port, single write port
	always_ff @(posedge clk) begin
		rd_handle_s1 <= mem_handle[scan_q[IDX_W-1:0]];
		if (clr_q) begin
			mem_handle[clr_idx_q[IDX_W-1:0]] <= '0;
		end else if (state_q == S_DONE) begin
			if (op_mode_q == MODE_FREE && hit_q) begin
				mem_handle[hit_idx_q] <= '0;
			end else if (op_mode_q == MODE_ALLOC && !hit_q && free_q
					&& len_q != '0 && len_q < LEN_W'(NAME_BYTES)) begin
				mem_handle[free_idx_q] <= key_q;
			end
		end
	end

	// attribute memories: one write, one read at the hit slot
	logic [IDX_W-1:0] attr_idx;
	logic attr_we, attr_new;
	assign attr_new = !hit_q;
	assign attr_idx = hit_q ? hit_idx_q : free_idx_q;
	assign attr_we = state_q == S_DONE && op_mode_q == MODE_ALLOC
		&& (hit_q || (free_q && len_q != '0 && len_q < LEN_W'(NAME_BYTES)));

	always_ff @(posedge clk) begin
		rd_storage_q <= mem_storage[hit_idx_q];
		rd_parent_q <= mem_parent[hit_idx_q];
		rd_format_q <= mem_format[hit_idx_q];
		rd_size_q <= mem_size[hit_idx_q];
		rd_dir_q <= mem_dir[hit_idx_q];
		if (attr_we) begin
			if (attr_new) begin
				mem_storage[attr_idx] <= held_storage_q;
				mem_parent[attr_idx] <= held_parent_q;
			end
			mem_format[attr_idx] <= fmt_q;
			mem_size[attr_idx] <= size_q;
			mem_dir[attr_idx] <= dir_q;
		end
	end

	logic look;
	assign look = op_mode_q == MODE_LOOKUP && hit_q;

	always_comb begin
		status_c = ST_NOTFOUND;
		result_c = '0;
		priority if (op_mode_q != MODE_ALLOC) begin
			status_c = hit_q ? ST_OK : ST_NOTFOUND;
			result_c = hit_q ? key_q : '0;
		end else if (hit_q) begin
			status_c = ST_OK;
			result_c = key_q;
		end else if (!free_q) begin
			status_c = ST_FULL;
		end else if (len_q == '0 || len_q >= LEN_W'(NAME_BYTES)) begin
			status_c = ST_BADLEN;
		end else begin
			status_c = ST_NEW;
			result_c = key_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_c;
			out_handle_q <= result_c;
			out_storage_q <= look ? rd_storage_q : '0;
			out_parent_q <= look ? rd_parent_q : '0;
			out_format_q <= look ? rd_format_q : '0;
			out_size_q <= look ? rd_size_q : '0;
			out_dir_q <= look ? rd_dir_q : 1'b0;
			out_count_q <= 8'(live_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign result_handle = out_handle_q;
	assign found_storage = out_storage_q;
	assign found_parent = out_parent_q;
	assign found_format = out_format_q;
	assign found_size = out_size_q;
	assign found_is_dir = out_dir_q;
	assign live_count = out_count_q;

	`PHT_ASSERT_IMP(a_stall_busy, state_q != S_IDLE, in_stall)
	`PHT_ASSERT_IMP(a_live_max, 1'b1, live_q <= CNT_W'(POOL_ENTRIES))
	`PHT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(live_count))
endmodule
